>>> design/mlrq_pkg.sv
package mlrq_pkg;

  // Fixed field geometry
  localparam int LANES      = 4;
  localparam int LANE_W     = 2;
  localparam int WORD_BITS  = 32;
  localparam int STATUS_W   = 3;
  localparam int MLEN_W     = 5;
  localparam int OCC_OUT_W  = 5;
  localparam int TOTAL_W    = 32;

  // Defaults for the sizing parameters of the top level
  localparam int SLOTS_DEF  = 16;
  localparam int WORDS_DEF  = 16;

  // Configuration port
  localparam int CFG_W      = 5;
  localparam int CFG_IDX_W  = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_BASE = 3'd4;

  typedef logic [CFG_W-1:0] cfg_val_t;

  localparam cfg_val_t SLOTS_RESET [LANES] = '{5'd8, 5'd16, 5'd4, 5'd16};
  localparam cfg_val_t LIMIT_RESET [LANES] = '{5'd4, 5'd16, 5'd8, 5'd16};

  // Result status codes
  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_OK      = 3'd0;
  localparam status_t ST_COMMIT  = 3'd1;
  localparam status_t ST_FULL    = 3'd2;
  localparam status_t ST_LONG    = 3'd3;
  localparam status_t ST_EMPTY   = 3'd4;
  localparam status_t ST_DISCARD = 3'd5;

  // Item kinds
  localparam logic KIND_SUBMIT = 1'b0;
  localparam logic KIND_DRAIN  = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
  } ctl_sts_t;

endpackage

>>> design/mlrq_item_if.sv
interface mlrq_item_if;
  logic                           valid;
  logic                           ready;
  logic                           kind;
  logic [mlrq_pkg::LANE_W-1:0]    lane;
  logic [mlrq_pkg::WORD_BITS-1:0] data_word;
  logic                           end_of_message;

  modport source (output valid, kind, lane, data_word, end_of_message, input ready);
  modport sink   (input valid, kind, lane, data_word, end_of_message, output ready);
endinterface

>>> design/mlrq_res_if.sv
interface mlrq_res_if;
  logic                           valid;
  logic                           ready;
  logic [mlrq_pkg::STATUS_W-1:0]  status;
  logic [mlrq_pkg::WORD_BITS-1:0] read_word;
  logic                           last_word;
  logic [mlrq_pkg::MLEN_W-1:0]    message_length;
  logic [mlrq_pkg::OCC_OUT_W-1:0] lane_occupancy;
  logic [mlrq_pkg::TOTAL_W-1:0]   lane_total_messages;

  modport source (output valid, status, read_word, last_word, message_length,
                  lane_occupancy, lane_total_messages, input ready);
  modport sink   (input valid, status, read_word, last_word, message_length,
                  lane_occupancy, lane_total_messages, output ready);
endinterface

>>> design/mlrq_cfg_if.sv
interface mlrq_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [mlrq_pkg::CFG_IDX_W-1:0] index;
  logic [mlrq_pkg::CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> design/mlrq_ctrl.sv
module mlrq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  mlrq_pkg::ctl_sts_t sts,
  output mlrq_pkg::ctl_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;

  // Sequencing: take a transaction, then execute once the result register frees up
  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.out_free) begin
          cmd.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Checks
  a_exec_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> sts.out_free)
    else $error("execute issued while result register is held");

  a_load_then_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == S_EXEC))
    else $error("load not followed by execute state");

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(cmd.load && cmd.exec))
    else $error("load and execute in the same cycle");

endmodule

>>> design/mlrq_datapath.sv
module mlrq_datapath #(
  parameter int SLOTS_PER_LANE = mlrq_pkg::SLOTS_DEF,
  parameter int WORDS_PER_SLOT = mlrq_pkg::WORDS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  mlrq_pkg::ctl_cmd_t             cmd,
  output mlrq_pkg::ctl_sts_t             sts,
  input  logic                           in_kind,
  input  logic [mlrq_pkg::LANE_W-1:0]    in_lane,
  input  logic [mlrq_pkg::WORD_BITS-1:0] in_data_word,
  input  logic                           in_eom,
  mlrq_cfg_if.sink                       cfg,
  mlrq_res_if.source                     result
);

  localparam int LANES = mlrq_pkg::LANES;
  localparam int CW    = mlrq_pkg::CFG_W;
  localparam int PW    = (SLOTS_PER_LANE > 1) ? $clog2(SLOTS_PER_LANE) : 1;
  localparam int OW    = $clog2(SLOTS_PER_LANE + 1);
  localparam int LW    = $clog2(WORDS_PER_SLOT + 1);
  localparam int RW    = (WORDS_PER_SLOT > 1) ? $clog2(WORDS_PER_SLOT) : 1;
  localparam int SCW   = (OW > CW) ? OW : CW;
  localparam int LCW   = (LW > CW) ? LW : CW;
  localparam int NSLOT = LANES * SLOTS_PER_LANE;
  localparam int NWORD = NSLOT * WORDS_PER_SLOT;
  localparam int SAW   = $clog2(NSLOT);
  localparam int AW    = $clog2(NWORD);
  localparam int WB    = mlrq_pkg::WORD_BITS;

  // Configuration registers
  mlrq_pkg::cfg_val_t cfg_slots [LANES];
  mlrq_pkg::cfg_val_t cfg_limit [LANES];

  // Per-lane ring state
  logic [PW-1:0] head     [LANES];
  logic [PW-1:0] tail     [LANES];
  logic [OW-1:0] occ      [LANES];
  logic [LW-1:0] wr_off   [LANES];
  logic [RW-1:0] rd_off   [LANES];
  logic          disc     [LANES];
  logic [31:0]   msgs     [LANES];

  // Shared stores
  logic [WB-1:0] store   [NWORD];
  logic [LW-1:0] len_mem [NSLOT];

  // Transaction held for the execute cycle
  logic                        it_kind;
  logic [mlrq_pkg::LANE_W-1:0] it_lane;
  logic [WB-1:0]               it_word;
  logic                        it_eom;
  logic [WB-1:0]               word_q;
  logic [LW-1:0]               len_q;

  // Result register
  logic                        out_valid;
  mlrq_pkg::status_t           out_status;
  logic [WB-1:0]               out_word;
  logic                        out_last;
  logic [mlrq_pkg::MLEN_W-1:0] out_mlen;
  logic [mlrq_pkg::OCC_OUT_W-1:0] out_occ;
  logic [mlrq_pkg::TOTAL_W-1:0]   out_total;

  // Execute-cycle values
  logic [SAW-1:0]    rd_sidx;
  logic [AW-1:0]     rd_addr;
  logic [SAW-1:0]    wr_sidx;
  logic [AW-1:0]     wr_addr;
  logic [SCW-1:0]    slots_eff;
  logic [LCW-1:0]    limit_eff;
  logic [SCW-1:0]    cfg_s;
  logic [LCW-1:0]    cfg_l;
  logic [LW-1:0]     wr1;
  logic [LW-1:0]     off1;
  mlrq_pkg::status_t st;
  logic [WB-1:0]     rword;
  logic              last;
  logic [LW-1:0]     mlen;
  logic [PW-1:0]     head_n;
  logic [PW-1:0]     tail_n;
  logic [OW-1:0]     occ_n;
  logic [LW-1:0]     wo_n;
  logic [RW-1:0]     ro_n;
  logic              disc_n;
  logic [31:0]       msgs_n;
  logic              store_we;
  logic              len_we;

  function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p,
                                              input logic [SCW-1:0] cnt);
    logic [SCW-1:0] p1;
    p1 = SCW'(p) + SCW'(1);
    return (p1 >= cnt) ? '0 : PW'(p1);
  endfunction

  assign cfg.ready    = 1'b1;
  assign sts.out_free = !out_valid || result.ready;

  // Read address of the drain side, from the incoming lane
  assign rd_sidx = SAW'(SAW'(in_lane) * SAW'(SLOTS_PER_LANE)) + SAW'(tail[in_lane]);
  assign rd_addr = AW'(AW'(rd_sidx) * AW'(WORDS_PER_SLOT)) + AW'(rd_off[in_lane]);

  // Write address of the submit side, from the held lane
  assign wr_sidx = SAW'(SAW'(it_lane) * SAW'(SLOTS_PER_LANE)) + SAW'(head[it_lane]);
  assign wr_addr = AW'(AW'(wr_sidx) * AW'(WORDS_PER_SLOT)) + AW'(wr_off[it_lane]);

  // Effective slot count and length limit with out-of-range values clamped
  always_comb begin
    cfg_s = SCW'(cfg_slots[it_lane]);
    cfg_l = LCW'(cfg_limit[it_lane]);
    if (cfg_s == '0) begin
      slots_eff = SCW'(1);
    end else if (cfg_s > SCW'(SLOTS_PER_LANE)) begin
      slots_eff = SCW'(SLOTS_PER_LANE);
    end else begin
      slots_eff = cfg_s;
    end
    if (cfg_l == '0) begin
      limit_eff = LCW'(1);
    end else if (cfg_l > LCW'(WORDS_PER_SLOT)) begin
      limit_eff = LCW'(WORDS_PER_SLOT);
    end else begin
      limit_eff = cfg_l;
    end
  end

  // Item execution
  always_comb begin
    st       = mlrq_pkg::ST_EMPTY;
    rword    = '0;
    last     = 1'b0;
    mlen     = '0;
    head_n   = head[it_lane];
    tail_n   = tail[it_lane];
    occ_n    = occ[it_lane];
    wo_n     = wr_off[it_lane];
    ro_n     = rd_off[it_lane];
    disc_n   = disc[it_lane];
    msgs_n   = msgs[it_lane];
    store_we = 1'b0;
    len_we   = 1'b0;
    wr1      = wr_off[it_lane] + LW'(1);
    off1     = LW'(rd_off[it_lane]) + LW'(1);
    if (it_kind == mlrq_pkg::KIND_SUBMIT) begin
      if (disc[it_lane]) begin
        st = mlrq_pkg::ST_DISCARD;
        if (it_eom) begin
          disc_n = 1'b0;
        end
      end else if (wr_off[it_lane] == '0 && SCW'(occ[it_lane]) >= slots_eff) begin
        st     = mlrq_pkg::ST_FULL;
        disc_n = !it_eom;
      end else if (LCW'(wr_off[it_lane]) >= limit_eff) begin
        st     = mlrq_pkg::ST_LONG;
        wo_n   = '0;
        disc_n = !it_eom;
      end else begin
        store_we = 1'b1;
        st       = mlrq_pkg::ST_OK;
        wo_n     = wr1;
        if (it_eom) begin
          len_we = 1'b1;
          head_n = next_slot(head[it_lane], slots_eff);
          occ_n  = occ[it_lane] + OW'(1);
          msgs_n = msgs[it_lane] + 32'd1;
          wo_n   = '0;
          st     = mlrq_pkg::ST_COMMIT;
          mlen   = wr1;
        end
      end
    end else if (occ[it_lane] != '0) begin
      st    = mlrq_pkg::ST_OK;
      rword = word_q;
      mlen  = len_q;
      if (off1 >= len_q) begin
        last   = 1'b1;
        ro_n   = '0;
        tail_n = next_slot(tail[it_lane], slots_eff);
        occ_n  = occ[it_lane] - OW'(1);
      end else begin
        ro_n = RW'(off1);
      end
    end
  end

  // Control state: configuration, lane pointers and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LANES; i++) begin
        cfg_slots[i] <= mlrq_pkg::SLOTS_RESET[i];
        cfg_limit[i] <= mlrq_pkg::LIMIT_RESET[i];
        head[i]      <= '0;
        tail[i]      <= '0;
        occ[i]       <= '0;
        wr_off[i]    <= '0;
        rd_off[i]    <= '0;
        disc[i]      <= 1'b0;
        msgs[i]      <= '0;
      end
      out_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        if (cfg.index < mlrq_pkg::CFG_LIMIT_BASE) begin
          cfg_slots[cfg.index[1:0]] <= cfg.data;
        end else begin
          cfg_limit[cfg.index[1:0]] <= cfg.data;
        end
      end
      if (cmd.exec) begin
        head[it_lane]   <= head_n;
        tail[it_lane]   <= tail_n;
        occ[it_lane]    <= occ_n;
        wr_off[it_lane] <= wo_n;
        rd_off[it_lane] <= ro_n;
        disc[it_lane]   <= disc_n;
        msgs[it_lane]   <= msgs_n;
        out_valid       <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Held transaction and result payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it_kind <= in_kind;
      it_lane <= in_lane;
      it_word <= in_data_word;
      it_eom  <= in_eom;
    end
    if (cmd.exec) begin
      out_status <= st;
      out_word   <= rword;
      out_last   <= last;
      out_mlen   <= mlrq_pkg::MLEN_W'(mlen);
      out_occ    <= mlrq_pkg::OCC_OUT_W'(occ_n);
      out_total  <= msgs_n;
    end
  end

  // Message word store, registered read
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      word_q <= store[rd_addr];
    end
    if (cmd.exec && store_we) begin
      store[wr_addr] <= it_word;
    end
  end

  // Stored message lengths, registered read
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      len_q <= len_mem[rd_sidx];
    end
    if (cmd.exec && len_we) begin
      len_mem[wr_sidx] <= wr1;
    end
  end

  assign result.valid               = out_valid;
  assign result.status              = out_status;
  assign result.read_word           = out_word;
  assign result.last_word           = out_last;
  assign result.message_length      = out_mlen;
  assign result.lane_occupancy      = out_occ;
  assign result.lane_total_messages = out_total;

  // Checks
  a_empty_has_no_data: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.status == mlrq_pkg::ST_EMPTY)
      |-> (result.read_word == '0 && !result.last_word))
    else $error("empty result carries data");

  a_last_only_on_drain: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.last_word) |-> (result.status == mlrq_pkg::ST_OK))
    else $error("last word flagged on a non-data result");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready)
      |=> (result.valid && $stable(result.status) && $stable(result.read_word)))
    else $error("waiting result changed");

endmodule

>>> design/multi_lane_message_ring_queue.sv
// An accepted transaction is held and executed into the result register once
//   that register is free.
// A new item is taken only after the last one executes; the registered read of
//   the word and length stores sits between the accept and the execute cycle.
// A held result stalls the execute step; input is taken again once it moves.
// Reset (rst, synchronous, active high) clears lane pointers, counters and the
//   result register and reloads configuration defaults; stores are not cleared.
module multi_lane_message_ring_queue #(
  parameter int SLOTS_PER_LANE = mlrq_pkg::SLOTS_DEF,
  parameter int WORDS_PER_SLOT = mlrq_pkg::WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  mlrq_item_if.sink   item,
  mlrq_res_if.source  result,
  mlrq_cfg_if.sink    cfg
);

  mlrq_pkg::ctl_cmd_t cmd;
  mlrq_pkg::ctl_sts_t sts;
  logic               in_ready;

  assign item.ready = in_ready;

  mlrq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mlrq_datapath #(
    .SLOTS_PER_LANE (SLOTS_PER_LANE),
    .WORDS_PER_SLOT (WORDS_PER_SLOT)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .in_kind      (item.kind),
    .in_lane      (item.lane),
    .in_data_word (item.data_word),
    .in_eom       (item.end_of_message),
    .cfg          (cfg),
    .result       (result)
  );

endmodule

>>> tb/sv/mlrq_scoreboard_pkg.sv
package mlrq_scoreboard_pkg;
  import mlrq_pkg::*;

  localparam int RING_SLOTS = SLOTS_DEF;
  localparam int SLOT_WORDS = WORDS_DEF;

  // One result transaction, field by field
  typedef struct packed {
    status_t                status;
    logic [WORD_BITS-1:0]   read_word;
    logic                   last_word;
    logic [MLEN_W-1:0]      message_length;
    logic [OCC_OUT_W-1:0]   lane_occupancy;
    logic [TOTAL_W-1:0]     lane_total_messages;
  } outcome_t;

  // Mirrors the lanes and checks results in order
  class lane_ring_tracker;
    cfg_val_t             slots_cfg [LANES];
    cfg_val_t             limit_cfg [LANES];
    int                   head [LANES];
    int                   tail [LANES];
    int                   held [LANES];
    int                   wr_off [LANES];
    int                   rd_off [LANES];
    bit                   discarding [LANES];
    bit [MLEN_W-1:0]      slot_len [LANES*RING_SLOTS];
    bit [WORD_BITS-1:0]   words [LANES*RING_SLOTS*SLOT_WORDS];
    bit [TOTAL_W-1:0]     committed [LANES];
    outcome_t             expected_q [$];
    int                   errors;
    int                   items_seen;
    int                   results_seen;
    int                   status_seen [8];

    function new();
      for (int ln = 0; ln < LANES; ln++) begin
        slots_cfg[ln] = SLOTS_RESET[ln];
        limit_cfg[ln] = LIMIT_RESET[ln];
      end
    endfunction

    // 0 reads as 1, anything above the physical size saturates
    static function int clamp(int v, int top);
      if (v == 0) return 1;
      if (v > top) return top;
      return v;
    endfunction

    static function int step_ring(int p, int count);
      return (p + 1 >= count) ? 0 : p + 1;
    endfunction

    function int slot_count(int ln);
      return clamp(int'(slots_cfg[ln]), RING_SLOTS);
    endfunction

    function int word_limit(int ln);
      return clamp(int'(limit_cfg[ln]), SLOT_WORDS);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function bit message_open(int ln);
      return wr_off[ln] != 0 || discarding[ln];
    endfunction

    function int waiting(int ln);
      return held[ln];
    endfunction

    function void write_register(int idx, cfg_val_t v);
      if (idx < int'(CFG_LIMIT_BASE)) slots_cfg[idx] = v;
      else limit_cfg[idx - int'(CFG_LIMIT_BASE)] = v;
    endfunction

    // Advance the lane state for one accepted item and queue its result
    function void note_item(logic kind, int ln, logic [WORD_BITS-1:0] w, logic eom);
      outcome_t o;
      int n;
      int lim;
      int base;
      int sidx;
      int off;
      int len;
      o = '0;
      o.status = ST_EMPTY;
      n = slot_count(ln);
      lim = word_limit(ln);
      if (kind == KIND_SUBMIT) begin
        if (discarding[ln]) begin
          o.status = ST_DISCARD;
          if (eom) discarding[ln] = 1'b0;
        end else if (wr_off[ln] == 0 && held[ln] >= n) begin
          o.status = ST_FULL;
          discarding[ln] = !eom;
        end else if (wr_off[ln] >= lim) begin
          o.status = ST_LONG;
          wr_off[ln] = 0;
          discarding[ln] = !eom;
        end else begin
          base = (ln * RING_SLOTS + head[ln]) * SLOT_WORDS;
          words[base + wr_off[ln]] = w;
          wr_off[ln]++;
          o.status = ST_OK;
          if (eom) begin
            slot_len[ln * RING_SLOTS + head[ln]] = MLEN_W'(wr_off[ln]);
            head[ln] = step_ring(head[ln], n);
            held[ln]++;
            committed[ln]++;
            o.message_length = MLEN_W'(wr_off[ln]);
            o.status = ST_COMMIT;
            wr_off[ln] = 0;
          end
        end
      end else if (held[ln] != 0) begin
        // drain: next word of the oldest committed message
        sidx = ln * RING_SLOTS + tail[ln];
        len = int'(slot_len[sidx]);
        off = rd_off[ln];
        if (off >= SLOT_WORDS) off = SLOT_WORDS - 1;
        o.read_word = words[sidx * SLOT_WORDS + off];
        o.message_length = MLEN_W'(len);
        o.status = ST_OK;
        if (off + 1 >= len) begin
          o.last_word = 1'b1;
          rd_off[ln] = 0;
          tail[ln] = step_ring(tail[ln], n);
          held[ln]--;
        end else begin
          rd_off[ln] = off + 1;
        end
      end
      o.lane_occupancy = OCC_OUT_W'(held[ln]);
      o.lane_total_messages = committed[ln];
      expected_q.push_back(o);
      items_seen++;
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task compare_field(string name, logic [WORD_BITS-1:0] got, logic [WORD_BITS-1:0] want);
      if (got !== want)
        report_mismatch($sformatf("result %0d: %s is %0h, expected %0h",
                                  results_seen, name, got, want));
    endtask

    task check_result(outcome_t got);
      outcome_t want;
      results_seen++;
      status_seen[got.status]++;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                  results_seen));
        return;
      end
      want = expected_q.pop_front();
      compare_field("status", WORD_BITS'(got.status), WORD_BITS'(want.status));
      compare_field("read_word", got.read_word, want.read_word);
      compare_field("last_word", WORD_BITS'(got.last_word), WORD_BITS'(want.last_word));
      compare_field("message_length", WORD_BITS'(got.message_length),
                    WORD_BITS'(want.message_length));
      compare_field("lane_occupancy", WORD_BITS'(got.lane_occupancy),
                    WORD_BITS'(want.lane_occupancy));
      compare_field("lane_total_messages", WORD_BITS'(got.lane_total_messages),
                    WORD_BITS'(want.lane_total_messages));
    endtask
  endclass

endpackage

>>> tb/sv/tb_multi_lane_message_ring_queue.sv
module tb_multi_lane_message_ring_queue;
  timeunit 1ns;
  timeprecision 1ps;
  import mlrq_pkg::*;
  import mlrq_scoreboard_pkg::*;

  localparam int CYCLE_LIMIT      = 1_000_000;
  localparam int PHASES           = 6;
  localparam int RANDOM_PER_PHASE = 200;
  localparam int DRAIN_PCT [PHASES] = '{40, 30, 45, 35, 20, 55};
  // Register values, mostly out of range, one per lane
  localparam cfg_val_t ODD_SLOTS [LANES] = '{5'd0, 5'd31, 5'd17, 5'd2};
  localparam cfg_val_t ODD_LIMIT [LANES] = '{5'd0, 5'd31, 5'd20, 5'd3};

  logic clk = 1'b0;
  logic rst;

  mlrq_item_if item_ch ();
  mlrq_res_if  res_ch ();
  mlrq_cfg_if  cfg_ch ();

  multi_lane_message_ring_queue DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  lane_ring_tracker tracker = new();

  int cycles = 0;
  int send_gap_max = 0;
  int take_gap_max = 0;
  int items_sent = 0;
  int results_taken = 0;
  int cfg_writes = 0;
  int msg_left [LANES];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycles, tracker.pending());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int pick_gap_max();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 3;
      default: return 11;
    endcase
  endfunction

  function automatic logic [WORD_BITS-1:0] rand_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Mostly legal lengths, some one-word messages, some past the limit
  function automatic int message_words(int lim);
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 1;
    if (r < 82) return $urandom_range(1, lim);
    return $urandom_range(lim + 1, lim + 3);
  endfunction

  // One input transaction, after a random gap
  task automatic send_item(logic kind, int ln, logic [WORD_BITS-1:0] w, logic eom);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    @(negedge clk);
    if (gap != 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.valid          <= 1'b1;
    item_ch.kind           <= kind;
    item_ch.lane           <= ln[LANE_W-1:0];
    item_ch.data_word      <= w;
    item_ch.end_of_message <= eom;
    do @(posedge clk); while (item_ch.ready !== 1'b1);
    tracker.note_item(kind, ln, w, eom);
    items_sent++;
    if (items_sent % 40 == 0) send_gap_max = pick_gap_max();
  endtask

  task automatic set_register(int idx, cfg_val_t v);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx[CFG_IDX_W-1:0];
    cfg_ch.data  <= v;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    tracker.write_register(idx, v);
    cfg_writes++;
  endtask

  // Rewrite all eight registers; mode picks low, high, out of range or random
  task automatic apply_settings(int mode);
    cfg_val_t s;
    cfg_val_t l;
    for (int ln = 0; ln < LANES; ln++) begin
      case (mode)
        1: begin
          s = 5'd1;
          l = 5'd1;
        end
        2: begin
          s = 5'd16;
          l = 5'd16;
        end
        3: begin
          s = ODD_SLOTS[ln];
          l = ODD_LIMIT[ln];
        end
        default: begin
          s = ($urandom_range(0, 9) == 0) ? cfg_val_t'($urandom_range(0, 31))
                                          : cfg_val_t'($urandom_range(1, 16));
          l = ($urandom_range(0, 9) == 0) ? cfg_val_t'($urandom_range(0, 31))
                                          : cfg_val_t'($urandom_range(1, 16));
        end
      endcase
      set_register(ln, s);
      set_register(int'(CFG_LIMIT_BASE) + ln, l);
    end
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Close open messages, empty every lane, then wait for the block to go quiet
  task automatic settle();
    for (int ln = 0; ln < LANES; ln++) begin
      if (tracker.message_open(ln)) send_item(KIND_SUBMIT, ln, rand_word(), 1'b1);
      while (tracker.waiting(ln) != 0)
        send_item(KIND_DRAIN, ln, rand_word(), 1'($urandom_range(0, 1)));
      msg_left[ln] = 0;
    end
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Directed cases at the reset register values
  task automatic directed();
    // drain of an empty lane, then the shortest message
    send_item(KIND_DRAIN, 0, '1, 1'b1);
    send_item(KIND_SUBMIT, 0, '1, 1'b1);
    // a partial message is not visible to drain
    send_item(KIND_SUBMIT, 1, 32'h8000_0001, 1'b0);
    send_item(KIND_DRAIN, 1, '0, 1'b0);
    send_item(KIND_SUBMIT, 1, 32'h7FFF_FFFE, 1'b1);
    // lane 0 at exactly its word limit
    for (int i = 0; i < 4; i++)
      send_item(KIND_SUBMIT, 0, 32'h0000_00FF << (i * 8), i == 3);
    // two words past the limit, the tail swallowed
    for (int i = 0; i < 6; i++)
      send_item(KIND_SUBMIT, 0, rand_word(), i == 5);
    // read both messages back and one more
    for (int i = 0; i < 6; i++)
      send_item(KIND_DRAIN, 0, rand_word(), 1'b0);
    // fill lane 2, then drop for full
    for (int i = 0; i < 4; i++)
      send_item(KIND_SUBMIT, 2, rand_word(), 1'b1);
    send_item(KIND_SUBMIT, 2, rand_word(), 1'b0);
    send_item(KIND_SUBMIT, 2, rand_word(), 1'b1);
    // full drop on a single-word message ends at once
    send_item(KIND_SUBMIT, 2, rand_word(), 1'b1);
  endtask

  // Well-formed messages with random content, drains, and some noise
  task automatic random_traffic(int drain_pct);
    int r;
    int ln;
    for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
      r = $urandom_range(0, 99);
      ln = $urandom_range(0, LANES - 1);
      if (r < drain_pct) begin
        send_item(KIND_DRAIN, ln, rand_word(), 1'($urandom_range(0, 1)));
      end else if (r < 92) begin
        if (msg_left[ln] == 0) msg_left[ln] = message_words(tracker.word_limit(ln));
        send_item(KIND_SUBMIT, ln, rand_word(), msg_left[ln] == 1);
        msg_left[ln]--;
      end else begin
        send_item(1'($urandom_range(0, 1)), ln, rand_word(), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // Result side: random stalls, check every transaction
  initial begin
    int stall;
    outcome_t got;
    res_ch.ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      stall = $urandom_range(0, take_gap_max);
      @(negedge clk);
      if (stall != 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (res_ch.valid !== 1'b1);
      got.status              = res_ch.status;
      got.read_word           = res_ch.read_word;
      got.last_word           = res_ch.last_word;
      got.message_length      = res_ch.message_length;
      got.lane_occupancy      = res_ch.lane_occupancy;
      got.lane_total_messages = res_ch.lane_total_messages;
      tracker.check_result(got);
      results_taken++;
      if (results_taken % 40 == 0) take_gap_max = pick_gap_max();
    end
  end

  // Main sequence
  initial begin
    item_ch.valid          = 1'b0;
    item_ch.kind           = KIND_SUBMIT;
    item_ch.lane           = '0;
    item_ch.data_word      = '0;
    item_ch.end_of_message = 1'b0;
    cfg_ch.valid           = 1'b0;
    cfg_ch.index           = '0;
    cfg_ch.data            = '0;
    rst                    = 1'b1;
    for (int ln = 0; ln < LANES; ln++) msg_left[ln] = 0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    directed();
    settle();
    for (int p = 0; p < PHASES; p++) begin
      if (p != 0) apply_settings(p);
      random_traffic(DRAIN_PCT[p]);
      settle();
    end

    if (tracker.pending() != 0)
      tracker.report_mismatch($sformatf("%0d results never arrived", tracker.pending()));
    $display("Ran %0d transactions and checked %0d results across %0d register writes",
             tracker.items_seen, tracker.results_seen, cfg_writes);
    $display("Statuses seen: ok %0d, commit %0d, full %0d, too long %0d, empty %0d, discard %0d",
             tracker.status_seen[ST_OK], tracker.status_seen[ST_COMMIT],
             tracker.status_seen[ST_FULL], tracker.status_seen[ST_LONG],
             tracker.status_seen[ST_EMPTY], tracker.status_seen[ST_DISCARD]);
    if (tracker.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> multi_lane_message_ring_queue.f
design/mlrq_pkg.sv
design/mlrq_item_if.sv
design/mlrq_res_if.sv
design/mlrq_cfg_if.sv
design/mlrq_ctrl.sv
design/mlrq_datapath.sv
design/multi_lane_message_ring_queue.sv
tb/sv/mlrq_scoreboard_pkg.sv
tb/sv/tb_multi_lane_message_ring_queue.sv
